[rtl/core/lrsl_pkg.sv]
package lrsl_pkg;

  localparam int MaxLen   = 4096;
  localparam int AddrW    = $clog2(MaxLen);
  localparam int CntW     = $clog2(MaxLen + 1);
  localparam int HashW    = 64;
  localparam int HalfW    = HashW / 2;
  localparam int ByteW    = 8;
  localparam int LenW     = 12;
  localparam int LenMax   = 4095;
  localparam int OutDataW = 16;

  typedef struct packed {
    logic load_byte;
    logic build_init;
    logic build_rd;
    logic build_wr;
    logic srch_init;
    logic mid_ld;
    logic pw_rd;
    logic pw_ld;
    logic wh_rd1;
    logic wh_rd2;
    logic wh_m0;
    logic wh_m1;
    logic wh_m2;
    logic wh_m3;
    logic wh_wr;
    logic cmp_init;
    logic cmp_a_rd;
    logic cmp_a;
    logic cmp_b_rd;
    logic next_j;
    logic next_i;
    logic found;
    logic miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic build_last;
    logic lo_lt_hi;
    logic wh_last;
    logic hit;
    logic j_last;
    logic i_last;
  } sts_t;

endpackage

[rtl/core/longest_repeated_substring_length.sv]
// Longest repeated substring length.
// Input stream: one string byte per item in s_axis_tdata, s_axis_tlast on the
// final byte. Bytes load at one per cycle while s_axis_tready is high.
// After the last byte the block leaves s_axis_tready low, builds prefix hashes
// and base powers (a read and a write per byte), then binary-searches the
// length over about log2(n) probes. Each probe computes every window hash (two
// prefix reads, a multiply sequence and a write per window, one shared 32x32
// multiplier) and compares window pairs through one memory read port (a read
// and a compare per pair, up to m*(m-1)/2 pairs; a match ends the probe early).
// Output stream: one item per string, length in m_axis_tdata, the overflow
// flag in m_axis_tuser. Bytes past 4096 are dropped and set the flag.
// The result is held in an output register until m_axis_tready; the block
// takes the bytes of the next string meanwhile and stalls only at the end of
// its next search. Reset clears the control state and the byte count; the
// stores need no clearing pass.
module longest_repeated_substring_length import lrsl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] ch
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [11:0] repeat_length, rest zero
  output logic                m_axis_tuser    // [0] overflow
);

  cmd_t            cmd;
  sts_t            sts;
  logic [LenW-1:0] len;

  lrsl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lrsl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ch_i            (s_axis_tdata),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .repeat_length_o (len),
    .overflow_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OutDataW-LenW){1'b0}}, len};

endmodule

[rtl/core/lrsl_ctrl.sv]
module lrsl_ctrl import lrsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic s_last_i,
  output logic s_ready_o,
  input  logic m_ready_i,
  output logic m_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StBuildRd = 5'd1;
  localparam logic [4:0] StBuildWr = 5'd2;
  localparam logic [4:0] StSrchIni = 5'd3;
  localparam logic [4:0] StSrchChk = 5'd4;
  localparam logic [4:0] StPwRd    = 5'd5;
  localparam logic [4:0] StPwLd    = 5'd6;
  localparam logic [4:0] StWhRd1   = 5'd7;
  localparam logic [4:0] StWhRd2   = 5'd8;
  localparam logic [4:0] StWhM0    = 5'd9;
  localparam logic [4:0] StWhM1    = 5'd10;
  localparam logic [4:0] StWhM2    = 5'd11;
  localparam logic [4:0] StWhM3    = 5'd12;
  localparam logic [4:0] StWhWr    = 5'd13;
  localparam logic [4:0] StCmpIni  = 5'd14;
  localparam logic [4:0] StCmpARd  = 5'd15;
  localparam logic [4:0] StCmpA    = 5'd16;
  localparam logic [4:0] StCmpBRd  = 5'd17;
  localparam logic [4:0] StCmpB    = 5'd18;
  localparam logic [4:0] StOut     = 5'd19;

  logic [4:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_byte = 1'b1;
          if (s_last_i) begin
            cmd_o.build_init = 1'b1;
            state_d = StBuildRd;
          end
        end
      end
      StBuildRd: begin
        cmd_o.build_rd = 1'b1;
        state_d = StBuildWr;
      end
      StBuildWr: begin
        cmd_o.build_wr = 1'b1;
        state_d = sts_i.build_last ? StSrchIni : StBuildRd;
      end
      StSrchIni: begin
        cmd_o.srch_init = 1'b1;
        state_d = StSrchChk;
      end
      StSrchChk: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.mid_ld = 1'b1;
          state_d = StPwRd;
        end else begin
          state_d = StOut;
        end
      end
      StPwRd: begin
        cmd_o.pw_rd = 1'b1;
        state_d = StPwLd;
      end
      StPwLd: begin
        cmd_o.pw_ld = 1'b1;
        state_d = StWhRd1;
      end
      StWhRd1: begin
        cmd_o.wh_rd1 = 1'b1;
        state_d = StWhRd2;
      end
      StWhRd2: begin
        cmd_o.wh_rd2 = 1'b1;
        state_d = StWhM0;
      end
      StWhM0: begin
        cmd_o.wh_m0 = 1'b1;
        state_d = StWhM1;
      end
      StWhM1: begin
        cmd_o.wh_m1 = 1'b1;
        state_d = StWhM2;
      end
      StWhM2: begin
        cmd_o.wh_m2 = 1'b1;
        state_d = StWhM3;
      end
      StWhM3: begin
        cmd_o.wh_m3 = 1'b1;
        state_d = StWhWr;
      end
      StWhWr: begin
        cmd_o.wh_wr = 1'b1;
        state_d = sts_i.wh_last ? StCmpIni : StWhRd1;
      end
      StCmpIni: begin
        cmd_o.cmp_init = 1'b1;
        state_d = StCmpARd;
      end
      StCmpARd: begin
        cmd_o.cmp_a_rd = 1'b1;
        state_d = StCmpA;
      end
      StCmpA: begin
        cmd_o.cmp_a = 1'b1;
        state_d = StCmpBRd;
      end
      StCmpBRd: begin
        cmd_o.cmp_b_rd = 1'b1;
        state_d = StCmpB;
      end
      StCmpB: begin
        if (sts_i.hit) begin
          cmd_o.found = 1'b1;
          state_d = StSrchChk;
        end else if (sts_i.j_last) begin
          if (sts_i.i_last) begin
            cmd_o.miss = 1'b1;
            state_d = StSrchChk;
          end else begin
            cmd_o.next_i = 1'b1;
            state_d = StCmpARd;
          end
        end else begin
          cmd_o.next_j = 1'b1;
          state_d = StCmpBRd;
        end
      end
      StOut: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_ready_i) m_valid_d = 1'b0;
    if (cmd_o.out_load) m_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

[rtl/core/lrsl_dp.sv]
module lrsl_dp import lrsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] ch_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [LenW-1:0]  repeat_length_o,
  output logic             overflow_o
);

  logic [ByteW-1:0] text_mem [MaxLen];
  logic [HashW-1:0] pre_mem  [MaxLen];
  logic [HashW-1:0] pow_mem  [MaxLen];
  logic [HashW-1:0] whs_mem  [MaxLen];

  logic [ByteW-1:0] text_rd_q;
  logic [HashW-1:0] pre_rd_q, pow_rd_q, whs_rd_q;

  logic [CntW-1:0]  cnt_q;
  logic             ovf_q;
  logic [HashW-1:0] h_q, pw_q, pwlen_q, hr_q, hl_q, acc_q, a_q;
  logic [AddrW-1:0] i_q, j_q, lo_q, hi_q, mid_q;
  logic [LenW-1:0]  len_q;
  logic             ovf_out_q;

  logic [HashW-1:0] sx, h_new, pw_new, prod;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [AddrW:0]   mid_sum;
  logic [CntW-1:0]  n_minus_mid;
  logic [AddrW-1:0] pre_ra;
  logic             full;

  assign full        = cnt_q >= CntW'(MaxLen);
  assign sx          = {{(HashW-ByteW){text_rd_q[ByteW-1]}}, text_rd_q};
  assign h_new       = (h_q << 8) + h_q + sx;
  assign pw_new      = (pw_q << 8) + pw_q;
  assign mid_sum     = ({1'b0, lo_q} + {1'b0, hi_q} + (AddrW+1)'(1)) >> 1;
  assign n_minus_mid = cnt_q - CntW'(mid_q);
  assign pre_ra      = cmd_i.wh_rd1 ? AddrW'(i_q + mid_q - AddrW'(1)) : AddrW'(i_q - AddrW'(1));
  assign mul_a       = cmd_i.wh_m3 ? hl_q[HashW-1:HalfW] : hl_q[HalfW-1:0];
  assign mul_b       = cmd_i.wh_m2 ? pwlen_q[HashW-1:HalfW] : pwlen_q[HalfW-1:0];
  assign prod        = mul_a * mul_b;

  assign sts_o.build_last = CntW'(i_q) == cnt_q - CntW'(1);
  assign sts_o.lo_lt_hi   = lo_q < hi_q;
  assign sts_o.wh_last    = CntW'(i_q) == n_minus_mid;
  assign sts_o.hit        = whs_rd_q == a_q;
  assign sts_o.j_last     = CntW'(j_q) == n_minus_mid;
  assign sts_o.i_last     = CntW'(i_q) + CntW'(1) == n_minus_mid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte && !full) text_mem[cnt_q[AddrW-1:0]] <= ch_i;
    if (cmd_i.build_rd) text_rd_q <= text_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_wr) pre_mem[i_q] <= h_new;
    if (cmd_i.wh_rd1 || cmd_i.wh_rd2) pre_rd_q <= pre_mem[pre_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_wr) pow_mem[i_q] <= pw_q;
    if (cmd_i.pw_rd) pow_rd_q <= pow_mem[mid_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wh_wr) whs_mem[i_q] <= hr_q - acc_q;
    if (cmd_i.cmp_a_rd) whs_rd_q <= whs_mem[i_q];
    if (cmd_i.cmp_b_rd) whs_rd_q <= whs_mem[j_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load_byte) begin
      if (full) ovf_q <= 1'b1;
      else      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      h_q  <= '0;
      pw_q <= HashW'(1);
    end else if (cmd_i.build_wr) begin
      h_q  <= h_new;
      pw_q <= pw_new;
    end

    if (cmd_i.build_init || cmd_i.pw_ld || cmd_i.cmp_init) i_q <= '0;
    else if (cmd_i.build_wr || cmd_i.wh_wr || cmd_i.next_i) i_q <= i_q + AddrW'(1);

    if (cmd_i.cmp_a_rd)    j_q <= i_q + AddrW'(1);
    else if (cmd_i.next_j) j_q <= j_q + AddrW'(1);

    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= AddrW'(cnt_q - CntW'(1));
    end else if (cmd_i.found) begin
      lo_q <= mid_q;
    end else if (cmd_i.miss) begin
      hi_q <= mid_q - AddrW'(1);
    end

    if (cmd_i.mid_ld) mid_q   <= mid_sum[AddrW-1:0];
    if (cmd_i.pw_ld)  pwlen_q <= pow_rd_q;
    if (cmd_i.wh_rd2) hr_q    <= pre_rd_q;
    if (cmd_i.wh_m0)  hl_q    <= (i_q == '0) ? '0 : pre_rd_q;
    if (cmd_i.wh_m1)  acc_q   <= prod;
    else if (cmd_i.wh_m2 || cmd_i.wh_m3) acc_q <= acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
    if (cmd_i.cmp_a)  a_q     <= whs_rd_q;

    if (cmd_i.out_load) begin
      len_q     <= (32'(lo_q) > 32'(LenMax)) ? LenW'(LenMax) : LenW'(lo_q);
      ovf_out_q <= ovf_q;
    end
  end

  assign repeat_length_o = len_q;
  assign overflow_o      = ovf_out_q;

endmodule

[rtl/core/lrsl_chk.sv]
module lrsl_chk import lrsl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic s_hs;
  assign s_hs = s_axis_tvalid && s_axis_tready;

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after last byte");

  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && !(s_hs && s_axis_tlast) |=> s_axis_tready)
    else $error("input ready dropped without a last byte");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:LenW] == '0)
    else $error("padding bits of result set");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind longest_repeated_substring_length lrsl_chk u_lrsl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/longest_repeated_substring_length_tb.sv]
`timescale 1ns / 100ps

module longest_repeated_substring_length_tb;
  import lrsl_pkg::*;

  localparam int ClkHalf   = 10;
  localparam int CycleMax  = 4_000_000;
  localparam int HoldCycles = 4000;
  localparam int ItemGoal  = 1600;

  typedef struct {
    logic [LenW-1:0] len;
    logic            ovf;
  } repeat_t;

  typedef struct {
    logic [ByteW-1:0] ch;
    logic             last;
    bit               typed;
    int unsigned      len;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  logic [ByteW-1:0] text_buf [MaxLen];
  int unsigned      stored_cnt;
  bit               dropped;
  repeat_t          expected_q [$];
  int unsigned      mismatch_cnt;
  int unsigned      result_cnt;
  int unsigned      item_cnt;
  int unsigned      cycle_cnt;
  bit               send_gaps;
  bit               recv_gaps;

  longest_repeated_substring_length dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  function automatic int unsigned longest_repeat(int unsigned n);
    bit [63:0] pre [];
    bit [63:0] pw [];
    bit        seen [bit [63:0]];
    bit [63:0] h;
    bit [63:0] b;
    bit [63:0] w;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    bit hit;
    pre = new[n];
    pw  = new[n];
    h = '0;
    for (i = 0; i < n; i++) begin
      b = {{56{text_buf[i][7]}}, text_buf[i]};
      h = h * 64'd257 + b;
      pre[i] = h;
      pw[i] = (i == 0) ? 64'd1 : pw[i-1] * 64'd257;
    end
    lo = 0;
    hi = (n > 0) ? n - 1 : 0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      seen.delete();
      hit = 1'b0;
      for (i = 0; i + mid <= n && !hit; i++) begin
        w = (i == 0) ? pre[mid-1] : pre[i+mid-1] - pre[i-1] * pw[mid];
        if (seen.exists(w)) hit = 1'b1;
        else seen[w] = 1'b1;
      end
      if (hit) lo = mid;
      else hi = mid - 1;
    end
    return (lo > LenMax) ? LenMax : lo;
  endfunction

  // advance the string state by one accepted item
  task automatic take_byte(input logic [ByteW-1:0] b, input logic l, input bit typed,
                           input int unsigned typed_len, input bit typed_ovf);
    repeat_t r;
    if (stored_cnt < MaxLen) begin
      text_buf[stored_cnt] = b;
      stored_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      r.len = LenW'(longest_repeat(stored_cnt));
      r.ovf = dropped;
      if (typed) begin
        r.len = LenW'(typed_len);
        r.ovf = typed_ovf;
      end
      expected_q.push_back(r);
      stored_cnt = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic drive_item(input logic [ByteW-1:0] b, input logic l, input bit typed = 1'b0,
                            input int unsigned typed_len = 0, input bit typed_ovf = 1'b0);
    while (send_gaps && $urandom_range(99) < 23) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    item_cnt++;
    take_byte(b, l, typed, typed_len, typed_ovf);
  endtask

  task automatic drive_string(input int unsigned n);
    logic [ByteW-1:0] pick [4];
    int unsigned mode;
    int unsigned period;
    int unsigned k;
    logic [ByteW-1:0] b;
    for (k = 0; k < 4; k++) pick[k] = ByteW'($urandom_range(255));
    mode = $urandom_range(2);
    period = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      case (mode)
        0: b = pick[$urandom_range(1)];
        1: b = pick[k % period];
        default: b = ByteW'($urandom_range(255));
      endcase
      if (mode == 1 && $urandom_range(9) == 0) b = ByteW'($urandom_range(255));
      drive_item(b, k == n - 1);
    end
  endtask

  // receiver: random stalls, one long hold-off after 20 results
  initial begin
    bit held;
    int unsigned k;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && result_cnt >= 20) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        for (k = 1; k < HoldCycles; k++) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready <= !(recv_gaps && $urandom_range(99) < 23);
    end
  end

  always @(posedge clk_i) begin
    repeat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: len=%0d ovf=%0b", m_axis_tdata, m_axis_tuser);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== OutDataW'(e.len) || m_axis_tuser !== e.ovf) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected len=%0d ovf=%0b, got len=%0d ovf=%0b",
                     result_cnt, e.len, e.ovf, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleMax) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    int unsigned k;
    int unsigned n;
    stored_cnt = 0;
    dropped = 1'b0;
    item_cnt = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    rows = '{
      '{8'h41, 1'b1, 1'b1, 0},
      '{8'h00, 1'b0, 1'b0, 0}, '{8'h00, 1'b1, 1'b1, 1},
      '{8'hFF, 1'b0, 1'b0, 0}, '{8'hFF, 1'b0, 1'b0, 0}, '{8'hFF, 1'b1, 1'b1, 2},
      '{8'h80, 1'b0, 1'b0, 0}, '{8'h7F, 1'b1, 1'b1, 0},
      '{8'h61, 1'b0, 1'b0, 0}, '{8'h62, 1'b0, 1'b0, 0}, '{8'h61, 1'b0, 1'b0, 0},
      '{8'h62, 1'b1, 1'b1, 2},
      '{8'hFF, 1'b0, 1'b0, 0}, '{8'h00, 1'b0, 1'b0, 0}, '{8'h80, 1'b0, 1'b0, 0},
      '{8'hFF, 1'b0, 1'b0, 0}, '{8'h00, 1'b0, 1'b0, 0}, '{8'h7F, 1'b1, 1'b0, 0},
      '{8'h01, 1'b0, 1'b0, 0}, '{8'h02, 1'b0, 1'b0, 0}, '{8'h03, 1'b0, 1'b0, 0},
      '{8'hAA, 1'b0, 1'b0, 0}, '{8'h55, 1'b0, 1'b0, 0}, '{8'h01, 1'b0, 1'b0, 0},
      '{8'h02, 1'b1, 1'b0, 0}
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) drive_item(rows[i].ch, rows[i].last, rows[i].typed, rows[i].len);

    // one string past capacity: every window repeats, so the length saturates
    for (k = 0; k < MaxLen + 4; k++)
      drive_item(8'h55, k == MaxLen + 3, k == MaxLen + 3, MaxLen - 1, 1'b1);

    while (item_cnt < MaxLen + 29 + ItemGoal) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      k = item_cnt - (MaxLen + 29);
      send_gaps = !(k > 600 && k < 900);
      recv_gaps = send_gaps;
      drive_string(n);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lrsl_pkg.sv
rtl/core/lrsl_ctrl.sv
rtl/core/lrsl_dp.sv
rtl/core/longest_repeated_substring_length.sv
rtl/core/lrsl_chk.sv
verif/longest_repeated_substring_length_tb.sv
